// ===== rtl/bhcd_pkg.sv =====
// Package: shared widths, register indexes and parameter defaults for the ball hold detector.
package bhcd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SPEED_W  = 8;
  localparam int LEVEL_W  = 12;
  localparam int ADJUST_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PHASE_W  = 3;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 32;

  localparam int BLOCK_SAMPLES_DEF   = 10;
  localparam int HISTORY_BLOCKS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF     = 12;
  localparam int TICKS_PER_PHASE_DEF = 100;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_CURRENT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST_OFFSET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHOTO_LIMIT    = 2'd3;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SPEED = 1'b1;

  // Blanking: acquisition resumes past PHASE_RESUME, blanking ends past PHASE_LAST.
  localparam logic [PHASE_W-1:0] PHASE_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_START  = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_RESUME = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_LAST   = 3'd4;

endpackage

// ===== rtl/ball_hold_current_detector_core.sv =====
// Ball hold detector core: block averaging of motor current, photo check and held latch.
//
// One beat is accepted per clock while s_axis_tready is high. A beat is either a 1 ms
// sample tick or a speed command; a tick that completes a block of BLOCK_SAMPLES samples
// yields one report beat, all other beats yield none. A report passes in order through
// the input register, the block/window update, the reciprocal multiply for the mean over
// BLOCK_SAMPLES*HISTORY_BLOCKS samples, then compare and held latch into the output
// register. Each stage holds only while its successor is full and stalled, so input keeps
// flowing while a report waits to be taken until two further reports queue up behind it.
// The window total is kept as a running sum over the stored block sums.
module ball_hold_current_detector_core #(
  parameter int BLOCK_SAMPLES   = bhcd_pkg::BLOCK_SAMPLES_DEF,
  parameter int HISTORY_BLOCKS  = bhcd_pkg::HISTORY_BLOCKS_DEF,
  parameter int SAMPLE_BITS     = bhcd_pkg::SAMPLE_BITS_DEF,
  parameter int TICKS_PER_PHASE = bhcd_pkg::TICKS_PER_PHASE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bhcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bhcd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [11:0] current_sample, [23:12] ball_sample, [31:24] speed_value
  input  logic [bhcd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] command
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] ball_held, [1] current_high, [13:2] current_mean, [14] photo_blocked,
  // [26:15] ball_raw, [31:27] zero
  output logic [bhcd_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import bhcd_pkg::*;

  localparam int SW   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int SMAX = (1 << SW) - 1;
  localparam int DIV  = BLOCK_SAMPLES * HISTORY_BLOCKS;
  localparam int BW   = $clog2(BLOCK_SAMPLES * SMAX + 1);
  localparam int TW   = $clog2(DIV * SMAX + 1);
  localparam int LW   = $clog2(DIV);
  localparam int SH   = TW + LW;
  localparam int MW   = TW + 1;
  localparam longint unsigned RECIP = ((64'd1 << SH) + longint'(DIV) - 1) / longint'(DIV);
  localparam int CW   = $clog2(BLOCK_SAMPLES);
  localparam int HW   = HISTORY_BLOCKS - 1;
  localparam int TCW  = (TICKS_PER_PHASE > 1) ? $clog2(TICKS_PER_PHASE) : 1;
  localparam int THW  = LEVEL_W + 3;

  localparam logic [CW-1:0]  CNT_LAST  = CW'(BLOCK_SAMPLES - 1);
  localparam logic [TCW-1:0] TICK_LAST = TCW'(TICKS_PER_PHASE - 1);
  localparam logic [MW-1:0]  RECIP_C   = MW'(RECIP);

  // configuration
  logic [LEVEL_W-1:0]         base_current;
  logic [LEVEL_W-1:0]         current_margin;
  logic signed [ADJUST_W-1:0] adjust_offset;
  logic [LEVEL_W-1:0]         photo_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_current   <= '0;
      current_margin <= '0;
      adjust_offset  <= '0;
      photo_limit    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_CURRENT:   base_current   <= cfg_data[LEVEL_W-1:0];
        REG_CURRENT_MARGIN: current_margin <= cfg_data[LEVEL_W-1:0];
        REG_ADJUST_OFFSET:  adjust_offset  <= cfg_data[ADJUST_W-1:0];
        REG_PHOTO_LIMIT:    photo_limit    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain
  logic v0, v1, v2, vo;
  logic rdy0, rdy1, rdy2, rdyo;

  assign rdyo = !vo || m_axis_tready;
  assign rdy2 = !v2 || rdyo;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign s_axis_tready = rdy0;
  assign m_axis_tvalid = vo;

  // input register
  logic                in_cmd;
  logic [SAMPLE_W-1:0] in_cur;
  logic [SAMPLE_W-1:0] in_ball;
  logic [SPEED_W-1:0]  in_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && s_axis_tvalid) begin
      in_cmd   <= s_axis_tuser;
      in_cur   <= s_axis_tdata[SAMPLE_W-1:0];
      in_ball  <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
      in_speed <= s_axis_tdata[2*SAMPLE_W+SPEED_W-1:2*SAMPLE_W];
    end
  end

  // block and blanking state
  logic [BW-1:0]      block_sum, block_sum_next;
  logic [BW-1:0]      history [HW];
  logic [TW-1:0]      hist_total, hist_total_next;
  logic [CW-1:0]      sample_count, sample_count_next;
  logic               acquire_paused, acquire_paused_next;
  logic [PHASE_W-1:0] blank_phase, blank_phase_next;
  logic [TCW-1:0]     tick_count, tick_count_next;
  logic [SPEED_W-1:0] last_speed, last_speed_next;

  logic               adv0;
  logic               report;
  logic [BW-1:0]      sum_inc;
  logic [TW-1:0]      report_total;
  logic [PHASE_W-1:0] phase_step;

  assign adv0 = v0 && rdy1;
  assign sum_inc = block_sum + {{(BW-SW){1'b0}}, in_cur[SW-1:0]};
  assign report_total = hist_total + TW'(sum_inc);

  always_comb begin
    block_sum_next      = block_sum;
    hist_total_next     = hist_total;
    sample_count_next   = sample_count;
    acquire_paused_next = acquire_paused;
    blank_phase_next    = blank_phase;
    tick_count_next     = tick_count;
    last_speed_next     = last_speed;
    report              = 1'b0;
    phase_step          = blank_phase;
    if (in_cmd == CMD_SPEED) begin
      if (in_speed != last_speed) begin
        acquire_paused_next = 1'b1;
        blank_phase_next    = PHASE_START;
      end
      last_speed_next = in_speed;
    end else begin
      if (!acquire_paused) begin
        if (sample_count == CNT_LAST) begin
          report            = 1'b1;
          block_sum_next    = '0;
          sample_count_next = '0;
          hist_total_next   = report_total - TW'(history[HW-1]);
        end else begin
          block_sum_next    = sum_inc;
          sample_count_next = sample_count + 1'b1;
        end
      end
      if (tick_count == TICK_LAST) begin
        tick_count_next = '0;
        if (blank_phase != PHASE_IDLE) begin
          phase_step = blank_phase + 1'b1;
        end
        if (phase_step > PHASE_RESUME) begin
          acquire_paused_next = 1'b0;
        end
        blank_phase_next = (phase_step > PHASE_LAST) ? PHASE_IDLE : phase_step;
      end else begin
        tick_count_next = tick_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum      <= '0;
      hist_total     <= '0;
      sample_count   <= '0;
      acquire_paused <= 1'b0;
      blank_phase    <= PHASE_IDLE;
      tick_count     <= '0;
      last_speed     <= '0;
      for (int i = 0; i < HW; i++) begin
        history[i] <= '0;
      end
    end else if (adv0) begin
      block_sum      <= block_sum_next;
      hist_total     <= hist_total_next;
      sample_count   <= sample_count_next;
      acquire_paused <= acquire_paused_next;
      blank_phase    <= blank_phase_next;
      tick_count     <= tick_count_next;
      last_speed     <= last_speed_next;
      if (report) begin
        history[0] <= sum_inc;
        for (int i = 1; i < HW; i++) begin
          history[i] <= history[i-1];
        end
      end
    end
  end

  // window total
  logic [TW-1:0]       t1_total;
  logic [SAMPLE_W-1:0] t1_ball;
  logic                t1_blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= adv0 && report;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && report) begin
      t1_total <= report_total;
      t1_ball  <= in_ball;
      t1_blank <= (blank_phase != PHASE_IDLE);
    end
  end

  // mean by reciprocal multiply
  logic [TW+MW-1:0]    p2_prod;
  logic [SAMPLE_W-1:0] p2_ball;
  logic                p2_blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      p2_prod  <= {{MW{1'b0}}, t1_total} * {{TW{1'b0}}, RECIP_C};
      p2_ball  <= t1_ball;
      p2_blank <= t1_blank;
    end
  end

  // compare, latch and report
  logic [SW-1:0]          mean;
  logic signed [THW-1:0]  thr;
  logic signed [THW-1:0]  mean_s;
  logic                   high;
  logic                   photo;
  logic                   held_latch, held_next;
  logic [SAMPLE_W-1:0]    mean_out;

  assign mean   = p2_prod[SH +: SW];
  assign mean_s = $signed({{(THW-SW){1'b0}}, mean});
  assign thr    = $signed({3'b000, base_current}) + $signed({3'b000, current_margin})
                + THW'(adjust_offset);
  assign high   = mean_s > thr;
  assign photo  = p2_ball < photo_limit;
  assign held_next = p2_blank ? 1'b0 : (photo && (high || held_latch));
  assign mean_out  = p2_blank ? '0 : SAMPLE_W'(mean);

  always_ff @(posedge clk) begin
    if (rst) begin
      vo         <= 1'b0;
      held_latch <= 1'b0;
    end else if (rdyo) begin
      vo <= v2;
      if (v2) begin
        held_latch <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdyo) begin
      m_axis_tdata <= {5'b00000, p2_ball, photo, mean_out, high, held_next};
    end
  end

endmodule
